// ===== hdl/pfsd_pkg.sv =====
// Shared constants and result codes for the palette file stream decoder.
package pfsd_pkg;

	localparam int unsigned MAX_COLORS_DEF = 256;

	localparam int unsigned LEN_W   = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 9;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned RAW_W   = 16;
	localparam int unsigned CH_W    = 8;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 72;

	// Header layout, byte offsets within the file
	localparam logic [LEN_W-1:0] HDR_END     = 32'd40;
	localparam logic [LEN_W-1:0] HDR_LAST    = 32'd39;
	localparam logic [LEN_W-1:0] MAGIC_B_POS = 32'h10;
	localparam logic [LEN_W-1:0] SIZE_POS    = 32'h20;

	// Magic words, first file byte in the low lane
	localparam logic [31:0] MAGIC_HEAD = 32'h4E43_4C52; // "RLCN"
	localparam logic [31:0] MAGIC_PLTT = 32'h504C_5454; // "TTLP"

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic {
		KIND_COLOUR = 1'b0,
		KIND_STATUS = 1'b1
	} result_kind_t;

	// Widen a five-bit channel to eight bits by replicating its top bits
	function automatic logic [CH_W-1:0] widen5(input logic [4:0] v);
		widen5 = {v, v[4:2]};
	endfunction

endpackage

// ===== hdl/palette_file_stream_decoder.sv =====
// Palette file stream decoder: header check, colour count, BGR555 to RGBA8888 expansion.
// An accepted byte passes the input register, then the result register, to reach m_tvalid.
// One byte per cycle unless m_tready stalls; the result register frees as it is taken.
// Per-byte work is a position compare, a byte merge and the count cap at byte 39.
// Reset (arst_n low): file length 0, byte position 0, all parse state cleared, no result.
module palette_file_stream_decoder
	import pfsd_pkg::*;
#(
	parameter int unsigned MAX_COLORS = MAX_COLORS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: file length
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LEN_W-1:0]       cfg_data,
	// file bytes in
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] file_byte
	// results out
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] header_error, [9:1] colour_total,
	                                           // [17:10] colour_index, [33:18] raw_colour,
	                                           // [41:34] red, [49:42] green, [57:50] blue,
	                                           // [65:58] alpha, [71:66] zero
	output logic                   m_tuser,   // [0] result_kind
	output logic                   m_tlast    // final_colour
);

	// ---------------------------------------------------------------
	// Configuration: keep the values derived from the length,
	// so the per-byte path needs only compares.
	// ---------------------------------------------------------------
	logic [LEN_W-1:0] fl_hdr_q;   // length minus header size
	logic [LEN_W-1:0] fl_last_q;  // length minus one
	logic             fl_short_q; // length below header size
	logic             fl_zero_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_hdr_q   <= '0 - HDR_END;
			fl_last_q  <= '1;
			fl_short_q <= 1'b1;
			fl_zero_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			fl_hdr_q   <= cfg_data - HDR_END;
			fl_last_q  <= cfg_data - LEN_W'(1);
			fl_short_q <= (cfg_data < HDR_END);
			fl_zero_q  <= (cfg_data == '0);
		end
	end

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;   // result register can take the next outcome
	logic              go;    // input register item is processed this cycle

	assign adv      = !m_tvalid || m_tready;
	assign go       = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Parse state
	// ---------------------------------------------------------------
	logic [LEN_W-1:0]  pos_q;
	logic [LEN_W-1:0]  size_q;
	logic [BYTE_W-1:0] held_q;
	logic              failed_q;
	logic [CNT_W-1:0]  expected_q;
	logic [CNT_W-1:0]  sent_q;

	// state as seen by the current byte (a new file starts clean)
	logic              first;
	logic [LEN_W-1:0]  size_b;
	logic              failed_b;
	logic [CNT_W-1:0]  expected_b;
	logic [CNT_W-1:0]  sent_b;

	// next state
	logic [LEN_W-1:0]  pos_d;
	logic [LEN_W-1:0]  size_d;
	logic [BYTE_W-1:0] held_d;
	logic              failed_d;
	logic [CNT_W-1:0]  expected_d;
	logic [CNT_W-1:0]  sent_d;

	// outcome
	logic              emit;
	result_kind_t      kind_d;
	logic              err_d;
	logic [CNT_W-1:0]  total_d;
	logic [IDX_W-1:0]  index_d;
	logic [RAW_W-1:0]  raw_d;
	logic [CH_W-1:0]   alpha_d;
	logic              final_d;

	// colour count
	logic              size_sel;
	logic [LEN_W-1:0]  size_eff;
	logic [LEN_W-2:0]  half;
	logic [CNT_W-1:0]  count;

	// header position decode
	logic              in_magic_a;
	logic              in_magic_b;
	logic              in_size;
	logic              at_hdr_last;
	logic              in_body;
	logic [1:0]        lane;
	logic [RAW_W-1:0]  raw_w;

	assign first       = (pos_q == '0);
	assign size_b      = first ? '0 : size_q;
	assign failed_b    = first ? fl_short_q : failed_q;
	assign expected_b  = first ? '0 : expected_q;
	assign sent_b      = first ? '0 : sent_q;

	assign lane        = pos_q[1:0];
	assign in_magic_a  = (pos_q < LEN_W'(4));
	assign in_magic_b  = (pos_q >= MAGIC_B_POS) && (pos_q < MAGIC_B_POS + LEN_W'(4));
	assign in_size     = (pos_q >= SIZE_POS) && (pos_q < SIZE_POS + LEN_W'(4));
	assign at_hdr_last = (pos_q == HDR_LAST);
	assign in_body     = (pos_q >= HDR_END);
	assign raw_w       = {byte_s1, held_q};

	// Fall back to the bytes left in the file when the size is zero or overruns it;
	// a length short of the header wraps that remainder huge, so clamp straight to the cap.
	assign size_sel = (size_b == '0) || fl_short_q || (size_b > fl_hdr_q);
	assign size_eff = size_sel ? fl_hdr_q : size_b;
	assign half     = size_eff[LEN_W-1:1];
	assign count    = (fl_short_q || (half > (LEN_W-1)'(MAX_COLORS))) ?
	                  CNT_W'(MAX_COLORS) : half[CNT_W-1:0];

	always_comb begin
		size_d     = size_b;
		held_d     = held_q;
		failed_d   = failed_b;
		expected_d = expected_b;
		sent_d     = sent_b;
		emit       = 1'b0;
		kind_d     = KIND_STATUS;
		err_d      = 1'b0;
		total_d    = '0;
		index_d    = '0;
		raw_d      = '0;
		alpha_d    = '0;
		final_d    = 1'b0;

		if (first && fl_short_q) begin
			// short file: report once on its first byte
			emit  = 1'b1;
			err_d = 1'b1;
		end

		if (!failed_b) begin
			if (in_magic_a) begin
				if (byte_s1 != MAGIC_HEAD[8*lane +: 8]) begin
					failed_d = 1'b1;
				end
			end else if (in_magic_b) begin
				if (byte_s1 != MAGIC_PLTT[8*lane +: 8]) begin
					failed_d = 1'b1;
				end
			end else if (in_size) begin
				size_d = size_b | (LEN_W'(byte_s1) << (8*lane));
			end else if (at_hdr_last) begin
				emit       = 1'b1;
				total_d    = count;
				expected_d = count;
			end else if (in_body) begin
				if (!pos_q[0]) begin
					// even body offset: hold the low byte of the word
					held_d = byte_s1;
				end else if (sent_b < expected_b) begin
					emit    = 1'b1;
					kind_d  = KIND_COLOUR;
					index_d = sent_b[IDX_W-1:0];
					raw_d   = raw_w;
					alpha_d = (sent_b == '0) ? '0 : ALPHA_OPAQUE;
					final_d = (sent_b + CNT_W'(1) == expected_b);
					sent_d  = sent_b + CNT_W'(1);
				end
			end
		end else if (at_hdr_last && !fl_short_q) begin
			// bad magic: report at the end of the header
			emit  = 1'b1;
			err_d = 1'b1;
		end

		// wrap at the last byte of the file; a zero length wraps every byte
		if (fl_zero_q || (pos_q >= fl_last_q)) begin
			pos_d = '0;
		end else begin
			pos_d = pos_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			size_q     <= '0;
			held_q     <= '0;
			failed_q   <= 1'b0;
			expected_q <= '0;
			sent_q     <= '0;
		end else if (go) begin
			pos_q      <= pos_d;
			size_q     <= size_d;
			held_q     <= held_d;
			failed_q   <= failed_d;
			expected_q <= expected_d;
			sent_q     <= sent_d;
		end
	end

	// ---------------------------------------------------------------
	// Result register: load on every processed byte that yields a result,
	// drop the valid when taken with nothing new behind it.
	// ---------------------------------------------------------------
	result_kind_t     kind_s2;
	logic             err_s2;
	logic [CNT_W-1:0] total_s2;
	logic [IDX_W-1:0] index_s2;
	logic [RAW_W-1:0] raw_s2;
	logic [CH_W-1:0]  alpha_s2;
	logic             final_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			kind_s2  <= kind_d;
			err_s2   <= err_d;
			total_s2 <= total_d;
			index_s2 <= index_d;
			raw_s2   <= raw_d;
			alpha_s2 <= alpha_d;
			final_s2 <= final_d;
		end
	end

	// red sits in the low five bits of the BGR555 word
	assign m_tdata = {6'b0,
	                  alpha_s2,
	                  widen5(raw_s2[14:10]),
	                  widen5(raw_s2[9:5]),
	                  widen5(raw_s2[4:0]),
	                  raw_s2,
	                  index_s2,
	                  total_s2,
	                  err_s2};
	assign m_tuser = kind_s2;
	assign m_tlast = final_s2;

`ifndef SYNTH
	// a colour result never carries status fields
	a_colour_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_COLOUR) |-> (m_tdata[9:0] == '0))
		else $error("colour result carries status fields");

	// the last-colour mark only appears on colour results
	a_last_is_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tuser == KIND_COLOUR))
		else $error("tlast on a status result");

	// never send more colours than the header announced
	a_sent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q <= expected_q)
		else $error("colour count exceeds announced total");

	// an error status reports no colours
	a_err_no_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_STATUS) && m_tdata[0] |-> (m_tdata[9:1] == '0))
		else $error("error status with nonzero total");
`endif

endmodule

// ===== tb/palette_check_pkg.sv =====
`timescale 1ns / 100ps
// Result prediction and comparison for the palette file stream decoder bench.
package palette_check_pkg;
	import pfsd_pkg::*;

	typedef struct packed {
		result_kind_t kind;
		logic         header_error;
		logic [8:0]   colour_total;
		logic [7:0]   colour_index;
		logic [15:0]  raw_colour;
		logic [7:0]   red;
		logic [7:0]   green;
		logic [7:0]   blue;
		logic [7:0]   alpha;
		logic         final_colour;
	} palette_result_t;

	class palette_tracker;
		logic [31:0]     file_length;
		logic [31:0]     position;
		logic [31:0]     size_word;
		logic [7:0]      low_byte;
		bit              failed;
		int unsigned     colours_due;
		int unsigned     colours_done;
		palette_result_t awaited_results[$];
		int              mismatches;

		function new();
			file_length  = '0;
			position     = '0;
			size_word    = '0;
			low_byte     = '0;
			failed       = 1'b0;
			colours_due  = 0;
			colours_done = 0;
			mismatches   = 0;
		endfunction

		function void set_length(logic [31:0] value);
			file_length = value;
		endfunction

		// Half the data size, capped; fall back to the bytes left in the file
		// when the size is zero or runs past the end.
		function logic [8:0] colour_count();
			longint unsigned span;
			longint unsigned count;
			span = size_word;
			if (span == 0 || 64'(HDR_END) + span > 64'(file_length))
				span = 64'(file_length) - 64'(HDR_END);
			count = span / 2;
			if (count > MAX_COLORS_DEF)
				count = MAX_COLORS_DEF;
			return 9'(count);
		endfunction

		function logic [7:0] spread5(logic [4:0] v);
			logic [7:0] wide;
			wide = 8'(v);
			return 8'((wide << 3) | (wide >> 2));
		endfunction

		function void predict_byte(logic [7:0] b);
			logic [31:0]     p;
			logic [15:0]     word;
			palette_result_t r;
			bit              emit;
			p    = position;
			r    = '0;
			emit = 1'b0;
			if (p == 0) begin
				size_word    = '0;
				low_byte     = '0;
				failed       = 1'b0;
				colours_due  = 0;
				colours_done = 0;
				if (file_length < HDR_END) begin
					failed         = 1'b1;
					r.kind         = KIND_STATUS;
					r.header_error = 1'b1;
					emit           = 1'b1;
				end
			end
			if (!failed) begin
				if (p < 4) begin
					if (b != 8'(MAGIC_HEAD >> (8 * p[1:0])))
						failed = 1'b1;
				end else if (p >= MAGIC_B_POS && p < MAGIC_B_POS + 4) begin
					if (b != 8'(MAGIC_PLTT >> (8 * p[1:0])))
						failed = 1'b1;
				end else if (p >= SIZE_POS && p < SIZE_POS + 4) begin
					size_word = size_word | (32'(b) << (8 * p[1:0]));
				end else if (p == HDR_LAST) begin
					colours_due    = colour_count();
					r.kind         = KIND_STATUS;
					r.colour_total = 9'(colours_due);
					emit           = 1'b1;
				end else if (p >= HDR_END) begin
					if (!p[0]) begin
						low_byte = b;
					end else if (colours_done < colours_due) begin
						word           = {b, low_byte};
						r.kind         = KIND_COLOUR;
						r.colour_index = 8'(colours_done);
						r.raw_colour   = word;
						r.red          = spread5(word[4:0]);
						r.green        = spread5(word[9:5]);
						r.blue         = spread5(word[14:10]);
						r.alpha        = (colours_done == 0) ? 8'd0 : ALPHA_OPAQUE;
						r.final_colour = (colours_done + 1 == colours_due);
						colours_done++;
						emit           = 1'b1;
					end
				end
			end else if (p == HDR_LAST && file_length >= HDR_END) begin
				r.kind         = KIND_STATUS;
				r.header_error = 1'b1;
				emit           = 1'b1;
			end
			if (33'(p) + 33'd1 >= 33'(file_length))
				position = '0;
			else
				position = p + 1;
			if (emit)
				awaited_results.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch: %s", msg);
		endtask

		task compare_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check_result(palette_result_t got);
			palette_result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("result %0h with nothing expected", got));
			end else begin
				want = awaited_results.pop_front();
				compare_field("result_kind", got.kind, want.kind);
				compare_field("header_error", got.header_error, want.header_error);
				compare_field("colour_total", got.colour_total, want.colour_total);
				compare_field("colour_index", got.colour_index, want.colour_index);
				compare_field("raw_colour", got.raw_colour, want.raw_colour);
				compare_field("red", got.red, want.red);
				compare_field("green", got.green, want.green);
				compare_field("blue", got.blue, want.blue);
				compare_field("alpha", got.alpha, want.alpha);
				compare_field("final_colour", got.final_colour, want.final_colour);
			end
		endtask
	endclass

endpackage

// ===== tb/palette_file_stream_decoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the palette file stream decoder: random files against a predictor.
module palette_file_stream_decoder_test;
	import pfsd_pkg::*;
	import palette_check_pkg::*;

	localparam int unsigned RANDOM_BYTES   = 950;
	localparam int unsigned SQUEEZE_CYCLES = 200;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned DRAIN_LIMIT    = 5000;

	typedef enum int {
		FILE_EXACT,
		FILE_ZERO_SIZE,
		FILE_OVERRUN,
		FILE_UNDERSIZE,
		FILE_BAD_MAGIC,
		FILE_NOISE
	} file_style_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [LEN_W-1:0]       cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] file_byte
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;          // [0] header_error, [9:1] colour_total,
	                                          // [17:10] colour_index, [33:18] raw_colour,
	                                          // [41:34] red, [49:42] green, [57:50] blue,
	                                          // [65:58] alpha, [71:66] zero
	logic                   m_tuser;          // [0] result_kind
	logic                   m_tlast;          // final_colour

	palette_tracker  tracker;
	palette_result_t got;
	int unsigned     bytes_sent  = 0;
	int unsigned     ready_stall = 0;
	bit              steady      = 1'b0;   // phase with no idling on either side
	bit              squeeze_req = 1'b0;
	bit              squeeze_on  = 1'b0;

	palette_file_stream_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly no gap, some short ones, a few long; none in a steady phase.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random stalls, overridden by the long hold-off.
	always @(posedge clk) begin
		int unsigned stall;
		if (squeeze_on) begin
			m_tready <= 1'b0;
		end else if (ready_stall > 0) begin
			m_tready    <= 1'b0;
			ready_stall <= ready_stall - 1;
		end else begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready    <= 1'b0;
				ready_stall <= stall - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hold off the receiver for a long stretch once asked, while bytes keep coming.
	initial begin
		while (!squeeze_req)
			@(posedge clk);
		squeeze_on <= 1'b1;
		repeat (SQUEEZE_CYCLES) @(posedge clk);
		squeeze_on <= 1'b0;
	end

	// Unpack every accepted result and check it against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.kind         = result_kind_t'(m_tuser);
			got.header_error = m_tdata[0];
			got.colour_total = m_tdata[9:1];
			got.colour_index = m_tdata[17:10];
			got.raw_colour   = m_tdata[33:18];
			got.red          = m_tdata[41:34];
			got.green        = m_tdata[49:42];
			got.blue         = m_tdata[57:50];
			got.alpha        = m_tdata[65:58];
			got.final_colour = m_tlast;
			tracker.check_result(got);
		end
	end

	// Offer one byte after a random gap; hold it until accepted, then predict.
	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.predict_byte(b);
		bytes_sent++;
	endtask

	task automatic write_length(logic [31:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_length(value);
	endtask

	// Stop offering bytes, wait for every predicted result, then let the pipe settle.
	task automatic drain();
		int unsigned waited;
		waited   = 0;
		s_tvalid <= 1'b0;
		while (tracker.awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (tracker.awaited_results.size() != 0) begin
			tracker.report($sformatf("%0d results never arrived",
				tracker.awaited_results.size()));
			tracker.awaited_results.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Change the length while idle; advance with filler bytes until a file boundary.
	task automatic start_phase(logic [31:0] len);
		drain();
		write_length(len);
		steady <= ($urandom_range(0, 4) == 0);
		while (tracker.position != 0)
			send_byte(8'($urandom));
	endtask

	function automatic logic [31:0] declared_for(file_style_t style, int unsigned data_bytes);
		case (style)
			FILE_ZERO_SIZE: return '0;
			FILE_OVERRUN: begin
				if ($urandom_range(0, 3) == 0)
					return 32'hFFFF_FFFF;
				return data_bytes + $urandom_range(1, 40);
			end
			FILE_UNDERSIZE: return $urandom_range(0, data_bytes);
			FILE_NOISE:     return $urandom;
			default:        return data_bytes;
		endcase
	endfunction

	function automatic file_style_t pick_style();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return FILE_EXACT;
		if (r < 45)
			return FILE_ZERO_SIZE;
		if (r < 60)
			return FILE_OVERRUN;
		if (r < 75)
			return FILE_UNDERSIZE;
		if (r < 90)
			return FILE_BAD_MAGIC;
		return FILE_NOISE;
	endfunction

	// Build a file image: random content, magic words and size unless noise,
	// one corrupted magic byte for a bad-magic file.
	task automatic send_file(int unsigned nbytes, file_style_t style, logic [31:0] declared);
		logic [7:0]  img[$];
		int unsigned bad;
		for (int unsigned i = 0; i < nbytes; i++)
			img.push_back(8'($urandom));
		if (style != FILE_NOISE && nbytes >= HDR_END) begin
			for (int k = 0; k < 4; k++) begin
				img[k]               = MAGIC_HEAD[8*k +: 8];
				img[MAGIC_B_POS + k] = MAGIC_PLTT[8*k +: 8];
				img[SIZE_POS + k]    = declared[8*k +: 8];
			end
			if (style == FILE_BAD_MAGIC) begin
				bad      = $urandom_range(0, 7);
				bad      = (bad < 4) ? bad : bad + MAGIC_B_POS - 4;
				img[bad] = img[bad] ^ 8'($urandom_range(1, 255));
			end
		end
		foreach (img[i])
			send_byte(img[i]);
	endtask

	task automatic header_phase(int unsigned data_bytes);
		file_style_t style;
		int unsigned files;
		start_phase(HDR_END + data_bytes);
		files = $urandom_range(1, 3);
		repeat (files) begin
			style = pick_style();
			send_file(HDR_END + data_bytes, style, declared_for(style, data_bytes));
		end
	endtask

	// Files below the header size; a length of zero makes every byte a file.
	task automatic short_phase(int unsigned len);
		int unsigned files;
		start_phase(len);
		files = $urandom_range(1, 3);
		repeat (files)
			send_file((len == 0) ? 1 : len, FILE_NOISE, '0);
	endtask

	// Long palette so the index reaches its top bit; squeeze the receiver meanwhile.
	task automatic big_phase();
		start_phase(HDR_END + 260);
		squeeze_req <= 1'b1;
		send_file(HDR_END + 260, FILE_EXACT, 32'd260);
	endtask

	// Largest length: a zero or large size caps the count; stream part, next phase realigns.
	task automatic max_phase();
		logic [31:0] declared;
		case ($urandom_range(0, 3))
			0:       declared = '0;
			1:       declared = 32'hFFFF_FFFF;
			2:       declared = 32'd600;
			default: declared = $urandom;
		endcase
		start_phase(32'hFFFF_FFFF);
		send_file(HDR_END + $urandom_range(8, 40), FILE_EXACT, declared);
	endtask

	initial begin
		int unsigned big_at;
		int unsigned max_at;
		bit          big_done;
		bit          max_done;
		int unsigned r;
		tracker  = new();
		big_at   = $urandom_range(150, 400);
		max_at   = $urandom_range(50, 600);
		big_done = 1'b0;
		max_done = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Zero length: each byte is its own short file.
		write_length(32'd0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		// Short files of one and two bytes.
		start_phase(32'd2);
		send_byte(8'hFF);
		send_byte(8'h00);
		start_phase(32'd1);
		send_byte(8'h52);

		while (bytes_sent < RANDOM_BYTES) begin
			if (!max_done && bytes_sent >= max_at) begin
				max_phase();
				max_done = 1'b1;
			end else if (!big_done && bytes_sent >= big_at) begin
				big_phase();
				big_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15)
					short_phase($urandom_range(0, 39));
				else if (r < 88)
					header_phase($urandom_range(0, 16));
				else
					header_phase($urandom_range(17, 60));
			end
		end
		if (!big_done)
			big_phase();
		if (!max_done)
			max_phase();

		drain();
		if (tracker.mismatches == 0)
			$display("palette_file_stream_decoder test passed");
		else
			$display("palette_file_stream_decoder test failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("palette_file_stream_decoder test failed");
		$finish;
	end

endmodule
